// ----- rtl/core/ccfs_pkg.sv -----
// Shared types and constants for the center crop frame statistics block.
// Used by every module under rtl/core; no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none

package ccfs_pkg;

    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int PIX_W       = 8;
    localparam int SUM_W       = 28;

    localparam int DEF_MAX_FRAME_SIDE = 1024;

    localparam logic [CFG_W-1:0] SRC_W_RESET  = 11'd176;
    localparam logic [CFG_W-1:0] SRC_H_RESET  = 11'd144;
    localparam logic [CFG_W-1:0] CROP_W_RESET = 11'd64;
    localparam logic [CFG_W-1:0] CROP_H_RESET = 11'd64;

    localparam logic [PIX_W-1:0] PIX_OFFSET     = 8'd128;
    localparam logic [PIX_W-1:0] MIN_CLEAR      = 8'd255;
    localparam logic [PIX_W-1:0] MAX_CLEAR      = 8'd0;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_STATS = 1'b1;

    // Output queue geometry.
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = 2;
    localparam int OQ_CNT_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SOURCE_WIDTH  = 2'd0,
        REG_SOURCE_HEIGHT = 2'd1,
        REG_CROP_WIDTH    = 2'd2,
        REG_CROP_HEIGHT   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic                    kind;
        logic signed [PIX_W-1:0] pixel_value;
        logic [PIX_W-1:0]        frame_min;
        logic [PIX_W-1:0]        frame_max;
        logic [SUM_W-1:0]        pixel_sum;
        logic                    is_last;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/center_crop_frame_stats_unit.sv -----
// Center crop with per-frame minimum, maximum and sum: top level.
// Depends on ccfs_pkg, ccfs_cfg, ccfs_core and ccfs_outq.
//
// Usage:
//   Pixels enter in raster order on the s_ valid/ready channel, one request
//   per pixel; s_frame_start marks the first pixel of a frame. Each pixel
//   inside the centered crop window leaves on the m_ channel as pixel - 128
//   (m_kind low). On the last pixel of a frame a statistics request follows
//   (m_kind high) with the minimum, maximum and sum of the cropped pixels.
//   m_is_last marks the final result caused by one input pixel.
//   The four geometry registers are written through cfg_wr_en, cfg_index and
//   cfg_wdata while no pixel is in flight.
// Timing:
//   One pixel is taken every cycle while the queue has two free entries. A
//   result is offered once its pixel has passed the input register and has
//   been written into the four-entry queue. An end-of-frame pixel inside the
//   window writes two entries at once, so statistics can cost an input stall
//   even when m_ready stays high.
// Reset and stalls:
//   Reset restores the default 176 x 144 frame with a 64 x 64 crop, clears
//   position and statistics and empties the queue. When m_ready is low the
//   queue fills; s_ready drops once fewer than two entries are free and the
//   input register holds a pixel.
`timescale 1ns / 1ps
`default_nettype none

module center_crop_frame_stats_unit #(
    parameter int MAX_FRAME_SIDE = ccfs_pkg::DEF_MAX_FRAME_SIDE
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [ccfs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ccfs_pkg::CFG_W-1:0]         cfg_wdata,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [ccfs_pkg::PIX_W-1:0]         s_pixel,
    input  wire logic                               s_frame_start,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_kind,
    output logic signed [ccfs_pkg::PIX_W-1:0]       m_pixel_value,
    output logic [ccfs_pkg::PIX_W-1:0]              m_frame_min,
    output logic [ccfs_pkg::PIX_W-1:0]              m_frame_max,
    output logic [ccfs_pkg::SUM_W-1:0]              m_pixel_sum,
    output logic                                    m_is_last
);

    localparam int SIDE_W = $clog2(MAX_FRAME_SIDE + 1);
    localparam int CNT_W  = $clog2(MAX_FRAME_SIDE);

    logic [SIDE_W-1:0] col_last, row_last, col_lo, col_hi, row_lo, row_hi;
    logic              room;
    logic [1:0]        wr_num;
    ccfs_pkg::result_t slot0, slot1, head;

    ccfs_cfg #(
        .MAX_FRAME_SIDE (MAX_FRAME_SIDE),
        .SIDE_W         (SIDE_W)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .col_last  (col_last),
        .row_last  (row_last),
        .col_lo    (col_lo),
        .col_hi    (col_hi),
        .row_lo    (row_lo),
        .row_hi    (row_hi)
    );

    ccfs_core #(
        .MAX_FRAME_SIDE (MAX_FRAME_SIDE),
        .SIDE_W         (SIDE_W),
        .CNT_W          (CNT_W)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel       (s_pixel),
        .s_frame_start (s_frame_start),
        .col_last      (col_last),
        .row_last      (row_last),
        .col_lo        (col_lo),
        .col_hi        (col_hi),
        .row_lo        (row_lo),
        .row_hi        (row_hi),
        .room          (room),
        .wr_num        (wr_num),
        .slot0         (slot0),
        .slot1         (slot1)
    );

    ccfs_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_num  (wr_num),
        .slot0   (slot0),
        .slot1   (slot1),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .head    (head)
    );

    assign m_kind        = head.kind;
    assign m_pixel_value = head.pixel_value;
    assign m_frame_min   = head.frame_min;
    assign m_frame_max   = head.frame_max;
    assign m_pixel_sum   = head.pixel_sum;
    assign m_is_last     = head.is_last;

endmodule

`default_nettype wire

// ----- rtl/core/ccfs_cfg.sv -----
// Configuration registers and the crop window geometry derived from them.
// Depends on ccfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccfs_cfg #(
    parameter int MAX_FRAME_SIDE = ccfs_pkg::DEF_MAX_FRAME_SIDE,
    parameter int SIDE_W         = $clog2(MAX_FRAME_SIDE + 1)
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [ccfs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ccfs_pkg::CFG_W-1:0]     cfg_wdata,
    output logic      [SIDE_W-1:0]              col_last,
    output logic      [SIDE_W-1:0]              row_last,
    output logic      [SIDE_W-1:0]              col_lo,
    output logic      [SIDE_W-1:0]              col_hi,
    output logic      [SIDE_W-1:0]              row_lo,
    output logic      [SIDE_W-1:0]              row_hi
);

    localparam int CMP_W = (SIDE_W > ccfs_pkg::CFG_W) ? SIDE_W : ccfs_pkg::CFG_W;
    localparam logic [CMP_W-1:0] MAX_SIDE = CMP_W'(MAX_FRAME_SIDE);

    logic [ccfs_pkg::CFG_W-1:0] src_w_reg, src_w_next;
    logic [ccfs_pkg::CFG_W-1:0] src_h_reg, src_h_next;
    logic [ccfs_pkg::CFG_W-1:0] crop_w_reg, crop_w_next;
    logic [ccfs_pkg::CFG_W-1:0] crop_h_reg, crop_h_next;

    logic [SIDE_W-1:0] col_last_reg, col_last_next;
    logic [SIDE_W-1:0] row_last_reg, row_last_next;
    logic [SIDE_W-1:0] col_lo_reg, col_lo_next;
    logic [SIDE_W-1:0] col_hi_reg, col_hi_next;
    logic [SIDE_W-1:0] row_lo_reg, row_lo_next;
    logic [SIDE_W-1:0] row_hi_reg, row_hi_next;

    logic [SIDE_W-1:0] sw, sh, cw, ch;

    // A zero side acts as one, and a side above the maximum acts as the maximum.
    function automatic logic [SIDE_W-1:0] side_of(input logic [ccfs_pkg::CFG_W-1:0] v);
        logic [CMP_W-1:0] wide;
        wide = CMP_W'(v);
        if (wide == '0) begin
            side_of = SIDE_W'(1);
        end else if (wide > MAX_SIDE) begin
            side_of = SIDE_W'(MAX_SIDE);
        end else begin
            side_of = SIDE_W'(wide);
        end
    endfunction

    always_comb begin
        src_w_next  = src_w_reg;
        src_h_next  = src_h_reg;
        crop_w_next = crop_w_reg;
        crop_h_next = crop_h_reg;
        if (!aresetn) begin
            src_w_next  = ccfs_pkg::SRC_W_RESET;
            src_h_next  = ccfs_pkg::SRC_H_RESET;
            crop_w_next = ccfs_pkg::CROP_W_RESET;
            crop_h_next = ccfs_pkg::CROP_H_RESET;
        end else if (cfg_wr_en) begin
            case (ccfs_pkg::cfg_reg_t'(cfg_index))
                ccfs_pkg::REG_SOURCE_WIDTH:  src_w_next  = cfg_wdata;
                ccfs_pkg::REG_SOURCE_HEIGHT: src_h_next  = cfg_wdata;
                ccfs_pkg::REG_CROP_WIDTH:    crop_w_next = cfg_wdata;
                ccfs_pkg::REG_CROP_HEIGHT:   crop_h_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    // The geometry is taken from the next register values, so it is always
    // in step with the registers themselves.
    always_comb begin
        sw = side_of(src_w_next);
        sh = side_of(src_h_next);
        cw = side_of(crop_w_next);
        ch = side_of(crop_h_next);
        if (cw > sw) begin
            cw = sw;
        end
        if (ch > sh) begin
            ch = sh;
        end
        col_last_next = sw - SIDE_W'(1);
        row_last_next = sh - SIDE_W'(1);
        col_lo_next   = (sw - cw) >> 1;
        row_lo_next   = (sh - ch) >> 1;
        col_hi_next   = col_lo_next + cw;
        row_hi_next   = row_lo_next + ch;
    end

    always_ff @(posedge aclk) begin
        src_w_reg    <= src_w_next;
        src_h_reg    <= src_h_next;
        crop_w_reg   <= crop_w_next;
        crop_h_reg   <= crop_h_next;
        col_last_reg <= col_last_next;
        row_last_reg <= row_last_next;
        col_lo_reg   <= col_lo_next;
        col_hi_reg   <= col_hi_next;
        row_lo_reg   <= row_lo_next;
        row_hi_reg   <= row_hi_next;
    end

    assign col_last = col_last_reg;
    assign row_last = row_last_reg;
    assign col_lo   = col_lo_reg;
    assign col_hi   = col_hi_reg;
    assign row_lo   = row_lo_reg;
    assign row_hi   = row_hi_reg;

endmodule

`default_nettype wire

// ----- rtl/core/ccfs_core.sv -----
// Input register, raster position counters, crop window test and running
// statistics. Produces up to two results per pixel. Depends on ccfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccfs_core #(
    parameter int MAX_FRAME_SIDE = ccfs_pkg::DEF_MAX_FRAME_SIDE,
    parameter int SIDE_W         = $clog2(MAX_FRAME_SIDE + 1),
    parameter int CNT_W          = $clog2(MAX_FRAME_SIDE)
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [ccfs_pkg::PIX_W-1:0] s_pixel,
    input  wire logic                       s_frame_start,
    input  wire logic [SIDE_W-1:0]          col_last,
    input  wire logic [SIDE_W-1:0]          row_last,
    input  wire logic [SIDE_W-1:0]          col_lo,
    input  wire logic [SIDE_W-1:0]          col_hi,
    input  wire logic [SIDE_W-1:0]          row_lo,
    input  wire logic [SIDE_W-1:0]          row_hi,
    input  wire logic                       room,
    output logic [1:0]                      wr_num,
    output ccfs_pkg::result_t               slot0,
    output ccfs_pkg::result_t               slot1
);

    logic                       in_valid_reg, in_valid_next;
    logic [ccfs_pkg::PIX_W-1:0] in_pixel_reg;
    logic                       in_start_reg;

    logic [CNT_W-1:0]           col_reg, col_next;
    logic [CNT_W-1:0]           row_reg, row_next;
    logic [ccfs_pkg::PIX_W-1:0] min_reg, min_next;
    logic [ccfs_pkg::PIX_W-1:0] max_reg, max_next;
    logic [ccfs_pkg::SUM_W-1:0] sum_reg, sum_next;

    logic                       advance;
    logic                       accept;
    logic [CNT_W-1:0]           col_eff, row_eff;
    logic [ccfs_pkg::PIX_W-1:0] min_eff, max_eff, min_upd, max_upd;
    logic [ccfs_pkg::SUM_W-1:0] sum_eff, sum_upd;
    logic                       in_win, row_end, frame_end;
    ccfs_pkg::result_t          pix_res, stat_res;

    assign advance = in_valid_reg && room;
    assign s_ready = !in_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        // A frame start restarts the position and drops any partial statistics.
        col_eff = in_start_reg ? '0 : col_reg;
        row_eff = in_start_reg ? '0 : row_reg;
        min_eff = in_start_reg ? ccfs_pkg::MIN_CLEAR : min_reg;
        max_eff = in_start_reg ? ccfs_pkg::MAX_CLEAR : max_reg;
        sum_eff = in_start_reg ? '0 : sum_reg;

        in_win = (SIDE_W'(col_eff) >= col_lo) && (SIDE_W'(col_eff) < col_hi) &&
                 (SIDE_W'(row_eff) >= row_lo) && (SIDE_W'(row_eff) < row_hi);

        min_upd = min_eff;
        max_upd = max_eff;
        sum_upd = sum_eff;
        if (in_win) begin
            if (in_pixel_reg < min_eff) begin
                min_upd = in_pixel_reg;
            end
            if (in_pixel_reg > max_eff) begin
                max_upd = in_pixel_reg;
            end
            sum_upd = sum_eff + ccfs_pkg::SUM_W'(in_pixel_reg);
        end

        // Positions past a shrunken frame still close the row or the frame.
        row_end   = SIDE_W'(col_eff) >= col_last;
        frame_end = row_end && (SIDE_W'(row_eff) >= row_last);

        pix_res.kind        = ccfs_pkg::KIND_PIXEL;
        pix_res.pixel_value = signed'(in_pixel_reg - ccfs_pkg::PIX_OFFSET);
        pix_res.frame_min   = '0;
        pix_res.frame_max   = '0;
        pix_res.pixel_sum   = '0;
        pix_res.is_last     = !frame_end;

        stat_res.kind        = ccfs_pkg::KIND_STATS;
        stat_res.pixel_value = '0;
        stat_res.frame_min   = min_upd;
        stat_res.frame_max   = max_upd;
        stat_res.pixel_sum   = sum_upd;
        stat_res.is_last     = 1'b1;

        slot0  = in_win ? pix_res : stat_res;
        slot1  = stat_res;
        wr_num = '0;
        if (advance) begin
            wr_num = {in_win && frame_end, in_win ^ frame_end};
        end

        col_next = col_reg;
        row_next = row_reg;
        min_next = min_reg;
        max_next = max_reg;
        sum_next = sum_reg;
        if (advance) begin
            if (frame_end) begin
                col_next = '0;
                row_next = '0;
                min_next = ccfs_pkg::MIN_CLEAR;
                max_next = ccfs_pkg::MAX_CLEAR;
                sum_next = '0;
            end else if (row_end) begin
                col_next = '0;
                row_next = row_eff + CNT_W'(1);
                min_next = min_upd;
                max_next = max_upd;
                sum_next = sum_upd;
            end else begin
                col_next = col_eff + CNT_W'(1);
                row_next = row_eff;
                min_next = min_upd;
                max_next = max_upd;
                sum_next = sum_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
            min_reg      <= ccfs_pkg::MIN_CLEAR;
            max_reg      <= ccfs_pkg::MAX_CLEAR;
            sum_reg      <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            min_reg      <= min_next;
            max_reg      <= max_next;
            sum_reg      <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_pixel_reg <= s_pixel;
            in_start_reg <= s_frame_start;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ccfs_outq.sv -----
// Four-entry result queue that takes up to two results a cycle and hands
// one a cycle to the result channel while m_ready is high. Depends on ccfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccfs_outq (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [1:0]  wr_num,
    input  wire ccfs_pkg::result_t slot0,
    input  wire ccfs_pkg::result_t slot1,
    output logic             room,
    output logic             m_valid,
    input  wire logic        m_ready,
    output ccfs_pkg::result_t head
);

    ccfs_pkg::result_t               entry_reg [ccfs_pkg::OQ_DEPTH];
    logic [ccfs_pkg::OQ_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [ccfs_pkg::OQ_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [ccfs_pkg::OQ_CNT_W-1:0]   count_reg, count_next;
    logic                            pop;

    assign m_valid = count_reg != '0;
    assign pop     = m_valid && m_ready;
    assign head    = entry_reg[rd_ptr_reg];
    // Room for a worst-case pixel plus statistics pair, ignoring this cycle's pop.
    assign room    = count_reg <= ccfs_pkg::OQ_CNT_W'(ccfs_pkg::OQ_DEPTH - 2);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + ccfs_pkg::OQ_PTR_W'(wr_num);
        rd_ptr_next = rd_ptr_reg + ccfs_pkg::OQ_PTR_W'(pop);
        count_next  = count_reg + ccfs_pkg::OQ_CNT_W'(wr_num) - ccfs_pkg::OQ_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_num != 2'd0) begin
            entry_reg[wr_ptr_reg] <= slot0;
        end
        if (wr_num == 2'd2) begin
            entry_reg[wr_ptr_reg + ccfs_pkg::OQ_PTR_W'(1)] <= slot1;
        end
    end

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= ccfs_pkg::OQ_CNT_W'(ccfs_pkg::OQ_DEPTH))
        else $error("result queue count out of range");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_num != 2'd0) |->
            ({1'b0, count_reg} + {2'b00, wr_num} <= (ccfs_pkg::OQ_CNT_W + 1)'(ccfs_pkg::OQ_DEPTH)))
        else $error("result queue written beyond its depth");

    a_ptr_count_agree: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != ccfs_pkg::OQ_CNT_W'(ccfs_pkg::OQ_DEPTH)) |->
            (ccfs_pkg::OQ_PTR_W'(wr_ptr_reg - rd_ptr_reg) ==
             ccfs_pkg::OQ_PTR_W'(count_reg)))
        else $error("result queue pointers disagree with count");

    a_head_kind_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && head.kind == ccfs_pkg::KIND_STATS) |-> head.is_last)
        else $error("statistics result without last flag");

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for center_crop_frame_stats_unit.
// Predicts cropped pixels and end-of-frame min/max/sum per request and checks
// every result in order. Depends on ccfs_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module testbench;

    localparam int HALF_PERIOD      = 6;
    localparam int RESET_CYCLES     = 6;
    localparam int MAX_SIDE         = ccfs_pkg::DEF_MAX_FRAME_SIDE;
    localparam int SETTLE_CYCLES    = 4;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int RANDOM_ITEMS     = 1150;
    localparam int MAX_PRINTED      = 100;

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                cfg_wr_en = 1'b0;
    ccfs_pkg::cfg_reg_t                  cfg_index = ccfs_pkg::REG_SOURCE_WIDTH;
    logic [ccfs_pkg::CFG_W-1:0]          cfg_wdata = '0;
    logic                                s_valid = 1'b0;
    wire                                 s_ready;
    logic [ccfs_pkg::PIX_W-1:0]          s_pixel = '0;
    logic                                s_frame_start = 1'b0;
    wire                                 m_valid;
    logic                                m_ready = 1'b0;
    wire                                 m_kind;
    wire signed [ccfs_pkg::PIX_W-1:0]    m_pixel_value;
    wire [ccfs_pkg::PIX_W-1:0]           m_frame_min;
    wire [ccfs_pkg::PIX_W-1:0]           m_frame_max;
    wire [ccfs_pkg::SUM_W-1:0]           m_pixel_sum;
    wire                                 m_is_last;

    // Geometry as the block should hold it, plus position and statistics.
    logic [ccfs_pkg::CFG_W-1:0] geom_reg [4];
    int                         pos_col;
    int                         pos_row;
    logic [ccfs_pkg::PIX_W-1:0] stat_min;
    logic [ccfs_pkg::PIX_W-1:0] stat_max;
    logic [ccfs_pkg::SUM_W-1:0] stat_sum;
    ccfs_pkg::result_t          crop_out_q [$];

    int error_count = 0;
    int items_sent = 0;
    int quiet_cycles = 0;
    bit tx_gapless = 1'b0;
    bit rx_gapless = 1'b0;
    bit long_hold_request = 1'b0;

    center_crop_frame_stats_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel       (s_pixel),
        .s_frame_start (s_frame_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_pixel_value (m_pixel_value),
        .m_frame_min   (m_frame_min),
        .m_frame_max   (m_frame_max),
        .m_pixel_sum   (m_pixel_sum),
        .m_is_last     (m_is_last)
    );

    always #HALF_PERIOD aclk = ~aclk;

    function automatic int clamp_side(input logic [ccfs_pkg::CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_SIDE)
            return MAX_SIDE;
        return v;
    endfunction

    function automatic void clear_stats();
        stat_min = ccfs_pkg::MIN_CLEAR;
        stat_max = ccfs_pkg::MAX_CLEAR;
        stat_sum = '0;
    endfunction

    function automatic void reset_prediction();
        geom_reg[ccfs_pkg::REG_SOURCE_WIDTH]  = ccfs_pkg::SRC_W_RESET;
        geom_reg[ccfs_pkg::REG_SOURCE_HEIGHT] = ccfs_pkg::SRC_H_RESET;
        geom_reg[ccfs_pkg::REG_CROP_WIDTH]    = ccfs_pkg::CROP_W_RESET;
        geom_reg[ccfs_pkg::REG_CROP_HEIGHT]   = ccfs_pkg::CROP_H_RESET;
        pos_col = 0;
        pos_row = 0;
        clear_stats();
    endfunction

    // Advances the position by one pixel and queues what that pixel produces.
    function automatic void crop_pixel(input logic [ccfs_pkg::PIX_W-1:0] pix, input logic fs);
        int                sw;
        int                sh;
        int                cw;
        int                ch;
        int                xo;
        int                yo;
        bit                in_window;
        bit                row_end;
        bit                frame_end;
        ccfs_pkg::result_t r;
        sw = clamp_side(geom_reg[ccfs_pkg::REG_SOURCE_WIDTH]);
        sh = clamp_side(geom_reg[ccfs_pkg::REG_SOURCE_HEIGHT]);
        cw = clamp_side(geom_reg[ccfs_pkg::REG_CROP_WIDTH]);
        ch = clamp_side(geom_reg[ccfs_pkg::REG_CROP_HEIGHT]);
        if (cw > sw)
            cw = sw;
        if (ch > sh)
            ch = sh;
        xo = (sw - cw) >> 1;
        yo = (sh - ch) >> 1;
        if (fs) begin
            pos_col = 0;
            pos_row = 0;
            clear_stats();
        end
        in_window = pos_col >= xo && pos_col < xo + cw && pos_row >= yo && pos_row < yo + ch;
        if (in_window) begin
            if (pix < stat_min)
                stat_min = pix;
            if (pix > stat_max)
                stat_max = pix;
            stat_sum = stat_sum + pix;
        end
        // A position left past the edge by a smaller frame ends the row or frame.
        row_end = pos_col >= sw - 1;
        frame_end = row_end && pos_row >= sh - 1;
        if (in_window) begin
            r = '0;
            r.kind = ccfs_pkg::KIND_PIXEL;
            r.pixel_value = pix - ccfs_pkg::PIX_OFFSET;
            r.is_last = !frame_end;
            crop_out_q.push_back(r);
        end
        if (frame_end) begin
            r = '0;
            r.kind = ccfs_pkg::KIND_STATS;
            r.frame_min = stat_min;
            r.frame_max = stat_max;
            r.pixel_sum = stat_sum;
            r.is_last = 1'b1;
            crop_out_q.push_back(r);
            clear_stats();
            pos_col = 0;
            pos_row = 0;
        end else if (row_end) begin
            pos_col = 0;
            pos_row = pos_row + 1;
        end else begin
            pos_col = pos_col + 1;
        end
    endfunction

    function automatic logic [ccfs_pkg::PIX_W-1:0] pick_pixel();
        logic [ccfs_pkg::PIX_W-1:0] corners [4];
        corners = '{8'd0, 8'd255, 8'd127, 8'd128};
        if ($urandom_range(0, 7) == 0)
            return corners[$urandom_range(0, 3)];
        return ccfs_pkg::PIX_W'($urandom_range(0, 255));
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (error_count < MAX_PRINTED)
            $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    task automatic drive_reg(input ccfs_pkg::cfg_reg_t idx,
                             input logic [ccfs_pkg::CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        geom_reg[idx] = val;
        @(posedge aclk);
    endtask

    task automatic write_geometry(input logic [ccfs_pkg::CFG_W-1:0] w,
                                  input logic [ccfs_pkg::CFG_W-1:0] h,
                                  input logic [ccfs_pkg::CFG_W-1:0] cw,
                                  input logic [ccfs_pkg::CFG_W-1:0] ch);
        drive_reg(ccfs_pkg::REG_SOURCE_WIDTH, w);
        drive_reg(ccfs_pkg::REG_SOURCE_HEIGHT, h);
        drive_reg(ccfs_pkg::REG_CROP_WIDTH, cw);
        drive_reg(ccfs_pkg::REG_CROP_HEIGHT, ch);
        cfg_wr_en <= 1'b0;
    endtask

    // Valid stays high from one request to the next when no gap is drawn.
    task automatic send_pixel(input logic [ccfs_pkg::PIX_W-1:0] pix, input logic fs);
        int unsigned gap;
        gap = tx_gapless ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= pix;
        s_frame_start <= fs;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        crop_pixel(pix, fs);
        items_sent++;
    endtask

    task automatic send_frame(input int npix, input bit with_start);
        for (int i = 0; i < npix; i++)
            send_pixel(pick_pixel(), (i == 0) ? with_start : ($urandom_range(0, 63) == 0));
    endtask

    // Pixels outside the window produce nothing, so allow the pipeline to empty too.
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (crop_out_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic test_default_geometry();
        // With 176 x 144 and a 64 x 64 crop the window starts at row 40.
        send_pixel(8'd0, 1'b1);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd128, 1'b0);
        wait_results_drained();
    endtask

    task automatic test_one_pixel_frames();
        // Zero in every register acts as one, so each pixel is a whole frame.
        write_geometry(11'd0, 11'd0, 11'd0, 11'd0);
        send_pixel(8'd0, 1'b1);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd127, 1'b1);
        send_pixel(8'd128, 1'b0);
        wait_results_drained();
    endtask

    task automatic test_crop_clamp();
        write_geometry(11'd3, 11'd2, 11'd2047, 11'd2047);
        send_pixel(8'd0, 1'b1);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd1, 1'b0);
        send_pixel(8'd254, 1'b0);
        send_pixel(8'd128, 1'b0);
        send_pixel(8'd127, 1'b0);
        wait_results_drained();
    endtask

    task automatic test_frame_restart();
        // The cut frame's statistics must not leak into the next one.
        write_geometry(11'd2, 11'd2, 11'd1, 11'd1);
        send_pixel(8'd200, 1'b1);
        send_pixel(8'd17, 1'b0);
        send_pixel(8'd9, 1'b1);
        send_pixel(8'd50, 1'b0);
        send_pixel(8'd60, 1'b0);
        send_pixel(8'd70, 1'b0);
        wait_results_drained();
    endtask

    task automatic test_shrink_mid_frame();
        // Stop at row 1, column 1 of a 4 x 4 frame before its single-pixel window.
        write_geometry(11'd4, 11'd4, 11'd1, 11'd1);
        send_pixel(8'd10, 1'b1);
        send_pixel(8'd20, 1'b0);
        send_pixel(8'd30, 1'b0);
        send_pixel(8'd40, 1'b0);
        send_pixel(8'd50, 1'b0);
        wait_results_drained();
        // In a 1 x 1 frame that position ends the frame with empty statistics.
        write_geometry(11'd1, 11'd1, 11'd1, 11'd1);
        send_pixel(8'd33, 1'b0);
        send_pixel(8'd77, 1'b0);
        wait_results_drained();
    endtask

    task automatic test_backpressure();
        write_geometry(11'd8, 11'd8, 11'd8, 11'd8);
        tx_gapless = 1'b1;
        rx_gapless = 1'b1;
        long_hold_request = 1'b1;
        send_frame(64, 1'b1);
        wait_results_drained();
        tx_gapless = 1'b0;
        rx_gapless = 1'b0;
        send_frame(64, 1'b1);
        wait_results_drained();
    endtask

    task automatic test_random_traffic();
        int                         stop_at;
        int                         frames;
        int                         npix;
        logic [ccfs_pkg::CFG_W-1:0] w;
        logic [ccfs_pkg::CFG_W-1:0] h;
        logic [ccfs_pkg::CFG_W-1:0] cw;
        logic [ccfs_pkg::CFG_W-1:0] ch;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            // Full-width rows are long, so they come rarely and one frame at a time.
            if ($urandom_range(0, 39) == 0 && items_sent + MAX_SIDE <= stop_at) begin
                w = ccfs_pkg::CFG_W'($urandom_range(1024, 2047));
                h = ccfs_pkg::CFG_W'($urandom_range(0, 1));
                frames = 1;
            end else begin
                w = ccfs_pkg::CFG_W'($urandom_range(0, 12));
                h = ccfs_pkg::CFG_W'($urandom_range(0, 8));
                frames = $urandom_range(1, 4);
            end
            cw = ccfs_pkg::CFG_W'(($urandom_range(0, 9) == 0) ?
                                  $urandom_range(0, 2047) : $urandom_range(0, 14));
            ch = ccfs_pkg::CFG_W'(($urandom_range(0, 9) == 0) ?
                                  $urandom_range(0, 2047) : $urandom_range(0, 10));
            write_geometry(w, h, cw, ch);
            tx_gapless = ($urandom_range(0, 3) == 0);
            rx_gapless = ($urandom_range(0, 3) == 0);
            npix = clamp_side(w) * clamp_side(h);
            for (int f = 0; f < frames; f++) begin
                case ($urandom_range(0, 9))
                    0: begin
                        send_frame($urandom_range(1, npix), 1'b1);
                    end
                    1: begin
                        send_frame(npix, 1'b0);
                    end
                    default: begin
                        send_frame(npix, 1'b1);
                    end
                endcase
            end
            wait_results_drained();
        end
        tx_gapless = 1'b0;
        rx_gapless = 1'b0;
    endtask

    // Result side: random ready gaps, plus one long hold on request.
    initial begin : result_sink
        int unsigned hold;
        forever begin
            if (long_hold_request) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                long_hold_request = 1'b0;
            end
            hold = rx_gapless ? 0 : $urandom_range(0, 9);
            if (hold != 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready))
                @(posedge aclk);
        end
    end

    always @(posedge aclk) begin : result_check
        ccfs_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (crop_out_q.size() == 0) begin
                report_mismatch("result with nothing expected, kind", m_kind, 0);
            end else begin
                want = crop_out_q.pop_front();
                if (m_kind !== want.kind)
                    report_mismatch("kind", m_kind, want.kind);
                if (m_pixel_value !== want.pixel_value)
                    report_mismatch("pixel_value", m_pixel_value, want.pixel_value);
                if (m_frame_min !== want.frame_min)
                    report_mismatch("frame_min", m_frame_min, want.frame_min);
                if (m_frame_max !== want.frame_max)
                    report_mismatch("frame_max", m_frame_max, want.frame_max);
                if (m_pixel_sum !== want.pixel_sum)
                    report_mismatch("pixel_sum", m_pixel_sum, want.pixel_sum);
                if (m_is_last !== want.is_last)
                    report_mismatch("is_last", m_is_last, want.is_last);
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        reset_prediction();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_geometry();
        test_one_pixel_frames();
        test_crop_clamp();
        test_frame_restart();
        test_shrink_mid_frame();
        test_backpressure();
        test_random_traffic();
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (crop_out_q.size() != 0)
            report_mismatch("results never delivered", 0, crop_out_q.size());
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/ccfs_pkg.sv
rtl/core/ccfs_cfg.sv
rtl/core/ccfs_core.sv
rtl/core/ccfs_outq.sv
rtl/core/center_crop_frame_stats_unit.sv
sim/testbench.sv
